// ----- src/ldf_pkg.sv -----
// ldf_pkg: shared types, constants and arithmetic helpers for the luma duotone fade pixel block.
// No dependencies; every other file of the block imports it.
package ldf_pkg;

  localparam int ChanW  = 8;
  localparam int ColorW = 24;
  localparam int PctW   = 7;
  localparam int IdxW   = 2;

  localparam logic [7:0] LumaWr  = 8'd54;
  localparam logic [7:0] LumaWg  = 8'd182;
  localparam logic [7:0] LumaWb  = 8'd19;
  localparam logic [7:0] Full    = 8'd255;
  localparam logic [6:0] PctMax  = 7'd100;
  // 5243 / 2^19 approximates 1/100, exact in floor for numerators below 43699
  localparam logic [12:0] Recip100 = 13'd5243;
  localparam int          RecipSh  = 19;

  typedef enum logic [IdxW-1:0] {
    REG_LIGHT = 2'd0,
    REG_DARK  = 2'd1,
    REG_FADE  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
  } pixel_t;

  typedef struct packed {
    pixel_t           src;
    logic [ChanW-1:0] grey;
  } luma_word_t;

  typedef struct packed {
    pixel_t src;
    pixel_t grad;
  } grad_word_t;

  function automatic logic [ChanW-1:0] mix(input logic [ChanW-1:0] hi,
                                           input logic [ChanW-1:0] lo,
                                           input logic [ChanW-1:0] w);
    logic [15:0] sum;
    sum = 16'(hi) * 16'(w) + 16'(lo) * 16'(Full - w);
    return sum[15:8];
  endfunction

  function automatic logic [ChanW-1:0] luma(input pixel_t p);
    logic [15:0] sum;
    sum = 16'(p.r) * 16'(LumaWr) + 16'(p.g) * 16'(LumaWg) + 16'(p.b) * 16'(LumaWb);
    return sum[15:8];
  endfunction

  // alpha = floor(255 * min(pct, 100) / 100)
  function automatic logic [ChanW-1:0] alpha_of(input logic [PctW-1:0] pct);
    logic [PctW-1:0] p;
    logic [14:0]     x;
    logic [27:0]     q;
    p = (pct > PctMax) ? PctMax : pct;
    x = (15'(p) << 8) - 15'(p);
    q = 28'(x) * 28'(Recip100);
    return q[RecipSh +: ChanW];
  endfunction

endpackage

// ----- src/ldf_ifs.sv -----
// ldf_ifs: valid/ready channel interfaces for pixel input, pixel result and register writes.
// Depends on ldf_pkg for widths.
interface ldf_in_if;
  import ldf_pkg::*;
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] in_red;
  logic [ChanW-1:0] in_green;
  logic [ChanW-1:0] in_blue;
  modport source (output valid, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, in_red, in_green, in_blue, output ready);
endinterface

interface ldf_out_if;
  import ldf_pkg::*;
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] out_red;
  logic [ChanW-1:0] out_green;
  logic [ChanW-1:0] out_blue;
  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

interface ldf_cfg_if;
  import ldf_pkg::*;
  logic              valid;
  logic              ready;
  logic [IdxW-1:0]   index;
  logic [ColorW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/ldf_cfg_regs.sv -----
// ldf_cfg_regs: register file for the gradient colors and the fade alpha.
// Depends on ldf_pkg and the ldf_cfg_if interface.
module ldf_cfg_regs (
  input  logic                     clk,
  input  logic                     rst,
  ldf_cfg_if.sink                  cfg,
  output logic [ldf_pkg::ColorW-1:0] light,
  output logic [ldf_pkg::ColorW-1:0] dark,
  output logic [ldf_pkg::ChanW-1:0]  alpha
);
  import ldf_pkg::*;

  assign cfg.ready = 1'b1;

  // alpha is stored already converted from percent
  always_ff @(posedge clk) begin
    if (rst) begin
      light <= {ColorW{1'b1}};
      dark  <= '0;
      alpha <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (reg_idx_t'(cfg.index))
        REG_LIGHT: light <= cfg.data;
        REG_DARK:  dark  <= cfg.data;
        REG_FADE:  alpha <= alpha_of(cfg.data[PctW-1:0]);
        default: ;
      endcase
    end
  end

endmodule

// ----- src/ldf_luma.sv -----
// ldf_luma: first pipeline stage, weighted grey of the source pixel.
// Depends on ldf_pkg.
module ldf_luma (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  ldf_pkg::pixel_t      up_word,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output ldf_pkg::luma_word_t  dn_word
);
  import ldf_pkg::*;

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_word.src  <= up_word;
      dn_word.grey <= luma(up_word);
    end
  end

endmodule

// ----- src/ldf_grad.sv -----
// ldf_grad: second pipeline stage, maps grey onto the dark-to-light gradient per channel.
// Depends on ldf_pkg.
module ldf_grad (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [ldf_pkg::ColorW-1:0] light,
  input  logic [ldf_pkg::ColorW-1:0] dark,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  ldf_pkg::luma_word_t        up_word,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output ldf_pkg::grad_word_t        dn_word
);
  import ldf_pkg::*;

  pixel_t light_px;
  pixel_t dark_px;

  assign light_px = light;
  assign dark_px  = dark;
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_word.src    <= up_word.src;
      dn_word.grad.r <= mix(light_px.r, dark_px.r, up_word.grey);
      dn_word.grad.g <= mix(light_px.g, dark_px.g, up_word.grey);
      dn_word.grad.b <= mix(light_px.b, dark_px.b, up_word.grey);
    end
  end

endmodule

// ----- src/ldf_blend.sv -----
// ldf_blend: last pipeline stage, fades gradient color over the source; output register.
// Depends on ldf_pkg.
module ldf_blend (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [ldf_pkg::ChanW-1:0] alpha,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  ldf_pkg::grad_word_t       up_word,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output ldf_pkg::pixel_t           dn_word
);
  import ldf_pkg::*;

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_word.r <= mix(up_word.grad.r, up_word.src.r, alpha);
      dn_word.g <= mix(up_word.grad.g, up_word.src.g, alpha);
      dn_word.b <= mix(up_word.grad.b, up_word.src.b, alpha);
    end
  end

endmodule

// ----- src/luma_duotone_fade_pixel.sv -----
// luma_duotone_fade_pixel: top level of the grey duotone colorize and fade pixel block.
// Depends on ldf_pkg, ldf_ifs, ldf_cfg_regs, ldf_luma, ldf_grad and ldf_blend.
//
// Usage:
//   pixel  - input channel, one RGB word per accepted handshake.
//   result - output channel, one RGB word for every input word, in order.
//   cfg    - register writes: index 0 light color, 1 dark color, 2 fade percent.
//            Always ready; writes to index 3 are dropped. Write only while idle.
// Each word passes three register stages in order: grey, gradient, blend. The
// blend register drives result directly.
// Throughput is one word per clock while result is not stalled: a stage reloads in
// the same cycle it hands its word on, since its ready follows the ready of the stage
// after it. Each stage is one layer of 8x8 products and their sum.
// When the receiver stalls, the last stage holds its word and stages behind it
// keep filling empty slots; pixel.ready drops only once all three stages are full.
// Reset (rst, synchronous) empties the pipeline and sets light to white, dark to
// black and fade to zero percent.
module luma_duotone_fade_pixel (
  input  logic      clk,
  input  logic      rst,
  ldf_in_if.sink    pixel,
  ldf_out_if.source result,
  ldf_cfg_if.sink   cfg
);
  import ldf_pkg::*;

  logic [ColorW-1:0] light;
  logic [ColorW-1:0] dark;
  logic [ChanW-1:0]  alpha;

  pixel_t     src_word;
  pixel_t     out_word;
  luma_word_t luma_word;
  grad_word_t grad_word;
  logic       luma_valid;
  logic       luma_ready;
  logic       grad_valid;
  logic       grad_ready;

  assign src_word.r = pixel.in_red;
  assign src_word.g = pixel.in_green;
  assign src_word.b = pixel.in_blue;

  ldf_cfg_regs u_regs (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .light (light),
    .dark  (dark),
    .alpha (alpha)
  );

  ldf_luma u_luma (
    .clk      (clk),
    .rst      (rst),
    .up_valid (pixel.valid),
    .up_ready (pixel.ready),
    .up_word  (src_word),
    .dn_valid (luma_valid),
    .dn_ready (luma_ready),
    .dn_word  (luma_word)
  );

  ldf_grad u_grad (
    .clk      (clk),
    .rst      (rst),
    .light    (light),
    .dark     (dark),
    .up_valid (luma_valid),
    .up_ready (luma_ready),
    .up_word  (luma_word),
    .dn_valid (grad_valid),
    .dn_ready (grad_ready),
    .dn_word  (grad_word)
  );

  ldf_blend u_blend (
    .clk      (clk),
    .rst      (rst),
    .alpha    (alpha),
    .up_valid (grad_valid),
    .up_ready (grad_ready),
    .up_word  (grad_word),
    .dn_valid (result.valid),
    .dn_ready (result.ready),
    .dn_word  (out_word)
  );

  assign result.out_red   = out_word.r;
  assign result.out_green = out_word.g;
  assign result.out_blue  = out_word.b;

endmodule
